>>> hw/rtl/utf8_to_utf16_decoder_unit_defines.svh
// Assertion macros shared by the UTF-8 to UTF-16 decoder RTL.
// Depends on clk_i and rst_ni being visible in the module that uses them.
`ifndef UTF8_TO_UTF16_DECODER_UNIT_DEFINES_SVH
`define UTF8_TO_UTF16_DECODER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge out of reset.
`define U8U16_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Condition must never be seen at a clock edge out of reset.
`define U8U16_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define U8U16_ASSERT(lbl, prop, msg)
`define U8U16_NEVER(lbl, cond, msg)
`endif
`endif

>>> hw/rtl/u8u16_pkg.sv
// Types and constants of the UTF-8 to UTF-16 decoder.
// No dependencies; used by every module of the block.
package u8u16_pkg;

  // Continuation bytes expected by the current sequence.
  typedef enum logic [1:0] {
    SEQ_NONE  = 2'd0,
    SEQ_TWO   = 2'd1,
    SEQ_THREE = 2'd2,
    SEQ_FOUR  = 2'd3
  } seq_len_e;

  localparam int unsigned ValW = 21;

  localparam logic [7:0]      LeadFourMask  = 8'hF0;
  localparam logic [7:0]      LeadThreeMask = 8'hE0;
  localparam logic [7:0]      LeadTwoMask   = 8'hC0;
  localparam logic [ValW-1:0] SuppOffset    = 21'h10000;
  localparam logic [15:0]     HighSurrBase  = 16'hD800;
  localparam logic [15:0]     LowSurrBase   = 16'hDC00;

  // One decoded result queued between front and back.
  typedef struct packed {
    logic        pair;      // unit is a high surrogate, a low one follows
    logic [15:0] unit;
    logic [9:0]  low_bits;  // payload of the low surrogate
  } entry_t;

endpackage

>>> hw/rtl/utf8_to_utf16_decoder_unit.sv
// UTF-8 to UTF-16 decoder: takes one UTF-8 byte per word and emits UTF-16
// code units. Throughput is one input word per cycle while the queue has
// room, so a four-byte sequence (two output words) streams at one byte per
// cycle unless the receiver stalls. When an accepted byte completes a
// character, the front end writes the decoded entry into the queue at the
// accepting edge, and the back end loads it into the output register once
// that register is free. A zero byte ends the string: it drops
// any partial sequence and emits unit 0. Continuation bytes are not checked;
// four-byte values are split into high then low surrogate. The front end
// stalls input only when the DEPTH-entry queue is full; the output register
// is refilled in the same cycle it is taken, so both sides stall on their own.
// Depends on u8u16_pkg and the front, queue and back modules.
module utf8_to_utf16_decoder_unit #(
  parameter int unsigned DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  byte_in_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] code_unit_o,
  output logic        last_of_run_o
);

  logic              accept;
  logic              push;
  logic              pop;
  logic              full;
  logic              empty;
  u8u16_pkg::entry_t push_entry;
  u8u16_pkg::entry_t head_entry;

  // Hold input whenever the queue has no room; every byte may push one entry.
  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  u8u16_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .byte_in_i (byte_in_i),
    .push_o    (push),
    .entry_o   (push_entry)
  );

  u8u16_fifo #(
    .DEPTH (DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_entry),
    .pop_i   (pop),
    .rdata_o (head_entry),
    .full_o  (full),
    .empty_o (empty)
  );

  u8u16_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (empty),
    .entry_i       (head_entry),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .code_unit_o   (code_unit_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

>>> hw/rtl/u8u16_front.sv
// Front end: accepts UTF-8 words, tracks the sequence state, emits decoded entries.
// Depends on u8u16_pkg and the assertion macros header.
`include "utf8_to_utf16_decoder_unit_defines.svh"
module u8u16_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          byte_in_i,
  output logic                push_o,
  output u8u16_pkg::entry_t   entry_o
);

  logic [1:0]                    pending_q, pending_d;
  u8u16_pkg::seq_len_e           len_q, len_d;
  logic [u8u16_pkg::ValW-1:0]    acc_q, acc_d;
  logic [u8u16_pkg::ValW-1:0]    acc_next;
  logic [u8u16_pkg::ValW-1:0]    supp;

  assign acc_next = {acc_q[u8u16_pkg::ValW-7:0], byte_in_i[5:0]};
  assign supp     = acc_next - u8u16_pkg::SuppOffset;

  always_comb begin
    pending_d = pending_q;
    len_d     = len_q;
    acc_d     = acc_q;
    push_o    = 1'b0;
    entry_o   = '0;
    if (accept_i) begin
      if (byte_in_i == 8'h00) begin
        // terminator: drop any partial sequence, emit unit 0
        pending_d = 2'd0;
        len_d     = u8u16_pkg::SEQ_NONE;
        acc_d     = '0;
        push_o    = 1'b1;
      end else if (pending_q != 2'd0) begin
        acc_d     = acc_next;
        pending_d = pending_q - 2'd1;
        if (pending_q == 2'd1) begin
          push_o = 1'b1;
          acc_d  = '0;
          len_d  = u8u16_pkg::SEQ_NONE;
          if (len_q == u8u16_pkg::SEQ_FOUR) begin
            entry_o.pair     = 1'b1;
            entry_o.unit     = u8u16_pkg::HighSurrBase | {6'd0, supp[19:10]};
            entry_o.low_bits = supp[9:0];
          end else begin
            entry_o.unit = acc_next[15:0];
          end
        end
      end else if ((byte_in_i & u8u16_pkg::LeadFourMask) == u8u16_pkg::LeadFourMask) begin
        acc_d     = {18'd0, byte_in_i[2:0]};
        pending_d = 2'd3;
        len_d     = u8u16_pkg::SEQ_FOUR;
      end else if ((byte_in_i & u8u16_pkg::LeadThreeMask) == u8u16_pkg::LeadThreeMask) begin
        acc_d     = {17'd0, byte_in_i[3:0]};
        pending_d = 2'd2;
        len_d     = u8u16_pkg::SEQ_THREE;
      end else if ((byte_in_i & u8u16_pkg::LeadTwoMask) == u8u16_pkg::LeadTwoMask) begin
        acc_d     = {16'd0, byte_in_i[4:0]};
        pending_d = 2'd1;
        len_d     = u8u16_pkg::SEQ_TWO;
      end else begin
        // ASCII or stray continuation: low 7 bits
        push_o       = 1'b1;
        entry_o.unit = {9'd0, byte_in_i[6:0]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 2'd0;
      len_q     <= u8u16_pkg::SEQ_NONE;
      acc_q     <= '0;
    end else begin
      pending_q <= pending_d;
      len_q     <= len_d;
      acc_q     <= acc_d;
    end
  end

  `U8U16_ASSERT(a_pending_within_len, (pending_q <= len_q), "pending exceeds sequence length")

endmodule

>>> hw/rtl/u8u16_fifo.sv
// Short queue of decoded entries between front and back end.
// Depends on u8u16_pkg and the assertion macros header.
`include "utf8_to_utf16_decoder_unit_defines.svh"
module u8u16_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  u8u16_pkg::entry_t wdata_i,
  input  logic              pop_i,
  output u8u16_pkg::entry_t rdata_o,
  output logic              full_o,
  output logic              empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  u8u16_pkg::entry_t mem_q [DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  `U8U16_NEVER(a_no_overflow, (push_i && full_o && !pop_i), "push into full queue")
  `U8U16_NEVER(a_no_underflow, (pop_i && empty_o), "pop from empty queue")

endmodule

>>> hw/rtl/u8u16_back.sv
// Back end: drains queued entries into UTF-16 words, splitting surrogate pairs.
// Depends on u8u16_pkg and the assertion macros header.
`include "utf8_to_utf16_decoder_unit_defines.svh"
module u8u16_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              empty_i,
  input  u8u16_pkg::entry_t entry_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [15:0]       code_unit_o,
  output logic              last_of_run_o
);

  logic        valid_q, valid_d;
  logic        second_q, second_d;
  logic [9:0]  low_q, low_d;
  logic [15:0] unit_q, unit_d;
  logic        last_q, last_d;
  logic        out_free;

  assign out_free = !valid_q || !out_stall_i;

  always_comb begin
    valid_d  = valid_q;
    second_d = second_q;
    low_d    = low_q;
    unit_d   = unit_q;
    last_d   = last_q;
    pop_o    = 1'b0;
    if (out_free) begin
      if (second_q) begin
        // finish the pair with the low surrogate
        valid_d  = 1'b1;
        unit_d   = u8u16_pkg::LowSurrBase | {6'd0, low_q};
        last_d   = 1'b1;
        second_d = 1'b0;
      end else if (!empty_i) begin
        pop_o    = 1'b1;
        valid_d  = 1'b1;
        unit_d   = entry_i.unit;
        last_d   = !entry_i.pair;
        second_d = entry_i.pair;
        low_d    = entry_i.low_bits;
      end else begin
        valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      second_q <= 1'b0;
    end else begin
      valid_q  <= valid_d;
      second_q <= second_d;
    end
  end

  always_ff @(posedge clk_i) begin
    low_q  <= low_d;
    unit_q <= unit_d;
    last_q <= last_d;
  end

  assign out_valid_o   = valid_q;
  assign code_unit_o   = unit_q;
  assign last_of_run_o = last_q;

  `U8U16_ASSERT(a_high_held, (!second_q || (valid_q && !last_q)),
                "low surrogate pending without high surrogate on output")

endmodule

>>> tb/utf8_to_utf16_decoder_unit_test.sv
// Self-checking testbench for utf8_to_utf16_decoder_unit: drives UTF-8 bytes and
// predicts the UTF-16 code units. Each output word is checked field by field.
// Depends on u8u16_pkg and the decoder RTL only.
`timescale 1ns / 1ps

module utf8_to_utf16_decoder_unit_test;

  localparam int unsigned CycleLimit  = 500000;  // far above the slowest correct run
  localparam int unsigned HoldCycles  = 80;      // long receiver hold-off
  localparam int unsigned TailCycles  = 8;       // settle time after the last word
  localparam int unsigned ReportLimit = 100;     // keep the log short on a bad build

  // One expected UTF-16 word as it leaves the block.
  typedef struct packed {
    logic [15:0] unit;
    logic        last_of_run;
  } utf16_word_t;

  logic        clk_i;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic [7:0]  byte_in_i   = 8'h00;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [15:0] code_unit_o;
  logic        last_of_run_o;

  // Decoder state of the predictor.
  logic [1:0]                 cont_left = 2'd0;                  // continuation bytes still to come
  u8u16_pkg::seq_len_e        seq_kind  = u8u16_pkg::SEQ_NONE;   // length of the sequence in flight
  logic [u8u16_pkg::ValW-1:0] code_acc  = '0;                    // code point gathered so far

  utf16_word_t     expected_units[$];     // words predicted, oldest first

  int unsigned mismatch_count = 0;
  int unsigned bytes_sent     = 0;
  int unsigned cycle_count    = 0;
  int unsigned send_idle_pct  = 0;        // chance the sender skips a cycle
  int unsigned stall_pct      = 0;        // chance the receiver stalls a cycle
  int unsigned hold_left      = 0;
  logic        hold_go        = 1'b0;

  utf8_to_utf16_decoder_unit uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .byte_in_i    (byte_in_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .code_unit_o  (code_unit_o),
    .last_of_run_o(last_of_run_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Hard stop: a hung handshake must not run forever.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("utf8_to_utf16_decoder_unit regression: fail");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    mismatch_count++;
    if (mismatch_count <= ReportLimit)
      $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
  endtask

  function automatic void expect_word(input logic [15:0] unit, input logic last_of_run);
    utf16_word_t w;
    w.unit        = unit;
    w.last_of_run = last_of_run;
    expected_units.push_back(w);
  endfunction

  // Advance the predicted decoder by one accepted byte and queue the words it emits.
  function automatic void decode_byte(input logic [7:0] b);
    logic [u8u16_pkg::ValW-1:0] offset_val;
    // A zero byte ends the string: drop any partial sequence, emit unit 0.
    if (b == 8'h00) begin
      cont_left = 2'd0;
      seq_kind  = u8u16_pkg::SEQ_NONE;
      code_acc  = '0;
      expect_word(16'h0000, 1'b1);
      return;
    end
    if (cont_left != 2'd0) begin
      // Any nonzero byte counts as a continuation here, top bits unchecked.
      code_acc  = {code_acc[u8u16_pkg::ValW-7:0], b[5:0]};
      cont_left = cont_left - 2'd1;
      if (cont_left == 2'd0) begin
        if (seq_kind == u8u16_pkg::SEQ_FOUR) begin
          // Split value minus the plane offset into high then low surrogate;
          // bits above 19 wrap away on overlong or out-of-range values.
          offset_val = code_acc - u8u16_pkg::SuppOffset;
          expect_word(u8u16_pkg::HighSurrBase | {6'b0, offset_val[19:10]}, 1'b0);
          expect_word(u8u16_pkg::LowSurrBase  | {6'b0, offset_val[9:0]},   1'b1);
        end else begin
          // Two- and three-byte values go out as their low 16 bits.
          expect_word(code_acc[15:0], 1'b1);
        end
        seq_kind = u8u16_pkg::SEQ_NONE;
        code_acc = '0;
      end
    end else if ((b & u8u16_pkg::LeadFourMask) == u8u16_pkg::LeadFourMask) begin
      // 0xF0..0xFF all start a four-byte sequence.
      code_acc      = '0;
      code_acc[2:0] = b[2:0];
      cont_left     = 2'd3;
      seq_kind      = u8u16_pkg::SEQ_FOUR;
    end else if ((b & u8u16_pkg::LeadThreeMask) == u8u16_pkg::LeadThreeMask) begin
      code_acc      = '0;
      code_acc[3:0] = b[3:0];
      cont_left     = 2'd2;
      seq_kind      = u8u16_pkg::SEQ_THREE;
    end else if ((b & u8u16_pkg::LeadTwoMask) == u8u16_pkg::LeadTwoMask) begin
      code_acc      = '0;
      code_acc[4:0] = b[4:0];
      cont_left     = 2'd1;
      seq_kind      = u8u16_pkg::SEQ_TWO;
    end else begin
      // ASCII and stray continuation bytes pass their low 7 bits.
      expect_word({9'b0, b[6:0]}, 1'b1);
    end
  endfunction

  // Check every word the block hands over against the oldest prediction.
  always @(posedge clk_i) begin : check_words
    utf16_word_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (expected_units.size() == 0) begin
        report_mismatch("unexpected word", code_unit_o, 16'h0000);
      end else begin
        want = expected_units.pop_front();
        if (code_unit_o !== want.unit)
          report_mismatch("code_unit", code_unit_o, want.unit);
        if (last_of_run_o !== want.last_of_run)
          report_mismatch("last_of_run", {15'b0, last_of_run_o}, {15'b0, want.last_of_run});
      end
    end
  end

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(negedge clk_i) begin
    if (hold_go) begin
      hold_left = HoldCycles;
      hold_go   = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // Offer one word, hold it until accepted, then predict. Enter and leave at a
  // falling edge; valid stays high so back-to-back words need no extra step.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    byte_in_i  <= b;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    decode_byte(b);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  // Pause the sender until every predicted word has come out.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_units.size() != 0) @(negedge clk_i);
    repeat (TailCycles) @(negedge clk_i);
  endtask

  function automatic logic [7:0] cont_byte();
    logic [7:0] r;
    r = 8'($urandom);
    return {2'b10, r[5:0]};
  endfunction

  // Send one random character: mostly well-formed with random content,
  // the rest raw noise, zero bytes and truncated sequences.
  task automatic send_char();
    int unsigned pick;
    logic [7:0]  r;
    logic [20:0] cp;
    int unsigned n;
    pick = $urandom_range(99);
    r    = 8'($urandom);
    if (pick < 22) begin
      send_byte({1'b0, r[6:0] | 7'h01});
    end else if (pick < 42) begin
      send_byte({3'b110, r[4:0]});
      send_byte(cont_byte());
    end else if (pick < 62) begin
      send_byte({4'b1110, r[3:0]});
      send_byte(cont_byte());
      send_byte(cont_byte());
    end else if (pick < 82) begin
      cp = 21'h10000 + 21'($urandom_range(21'h0FFFFF));
      send_byte({5'b11110, cp[20:18]});
      send_byte({2'b10, cp[17:12]});
      send_byte({2'b10, cp[11:6]});
      send_byte({2'b10, cp[5:0]});
    end else if (pick < 90) begin
      send_byte(r);
    end else if (pick < 93) begin
      send_byte(8'h00);
    end else begin
      // Truncated sequence: a lead, too few continuations, then a zero or
      // a fresh lead that gets swallowed as a continuation.
      send_byte({4'b1111, r[3:0]});
      n = $urandom_range(2);
      repeat (n) send_byte(cont_byte());
      send_byte(r[7] ? 8'h00 : {3'b110, r[4:0]});
    end
  endtask

  task automatic run_random(input int unsigned count);
    int unsigned goal;
    goal = bytes_sent + count;
    while (bytes_sent < goal) send_char();
  endtask

  // Field extremes and every special case, one after the other.
  task automatic test_directed();
    logic [7:0] seq[$];
    seq = '{8'h00, 8'h01, 8'h7F, 8'h80, 8'hBF,   // zero, ASCII limits, stray continuations
            8'hC3, 8'h41,                        // two-byte lead, unchecked continuation
            8'hE2, 8'h82, 8'hAC,                 // three-byte character
            8'hF0, 8'h9F, 8'h98, 8'h80,          // four-byte character, surrogate pair
            8'hF8, 8'h80, 8'h80, 8'h80,          // 0xF8 lead, overlong value wraps
            8'hFF, 8'hFF, 8'hFF, 8'hFF,          // out-of-range value, top bits dropped
            8'hE2, 8'h00};                       // zero byte inside a sequence
    send_idle_pct = 0;
    stall_pct     = 0;
    foreach (seq[i]) send_byte(seq[i]);
    drain_results();
  endtask

  task automatic test_no_idle();
    send_idle_pct = 0;
    stall_pct     = 0;
    run_random(400);
    drain_results();
  endtask

  task automatic test_sender_idle();
    send_idle_pct = 84;
    stall_pct     = 0;
    run_random(300);
    drain_results();
  endtask

  task automatic test_receiver_stall();
    send_idle_pct = 0;
    stall_pct     = 84;
    run_random(350);
    drain_results();
  endtask

  task automatic test_both_idle();
    send_idle_pct = 35;
    stall_pct     = 35;
    run_random(350);
    drain_results();
  endtask

  // Hold the receiver off while the sender keeps going, so the queue fills
  // and the input stalls; then pause until every word has drained.
  task automatic test_queue_full();
    send_idle_pct = 0;
    stall_pct     = 10;
    hold_go       = 1'b1;
    run_random(200);
    drain_results();
  endtask

  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed();
    test_no_idle();
    test_sender_idle();
    test_receiver_stall();
    test_both_idle();
    test_queue_full();

    if (mismatch_count == 0) begin
      $display("utf8_to_utf16_decoder_unit regression: pass");
    end else begin
      $display("utf8_to_utf16_decoder_unit regression: fail");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/u8u16_pkg.sv
hw/rtl/u8u16_front.sv
hw/rtl/u8u16_fifo.sv
hw/rtl/u8u16_back.sv
hw/rtl/utf8_to_utf16_decoder_unit.sv
tb/utf8_to_utf16_decoder_unit_test.sv
